@@ hw/rtl/mm4_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mm4_pkg
// Shared widths, opcodes and controller/datapath types for the 4x4 matrix
// multiplier.
// ---------------------------------------------------------------------------
package mm4_pkg;

  localparam int ELEM_W            = 32;
  localparam int ROW_W             = 2;
  localparam int OPCODE_W          = 2;
  localparam int IO_COLS           = 4;
  localparam int DIM_DEFAULT       = 4;
  localparam int FRAC_BITS_DEFAULT = 16;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_LEFT  = 0,
    OP_LOAD_RIGHT = 1,
    OP_MULTIPLY   = 2
  } opcode_t;

  typedef struct packed {
    logic load_left;
    logic load_right;
    logic issue;
    logic first;
    logic last;
    logic emit;
    logic emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic row_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/mm4_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mm4_if
// Valid/ready channels for load/multiply requests and product rows.
// ---------------------------------------------------------------------------
interface mm4_in_if;
  import mm4_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ROW_W-1:0]    row_index;
  elem_t               elem0;
  elem_t               elem1;
  elem_t               elem2;
  elem_t               elem3;

  modport source (output valid, opcode, row_index, elem0, elem1, elem2, elem3,
                  input ready);
  modport sink   (input valid, opcode, row_index, elem0, elem1, elem2, elem3,
                  output ready);
endinterface

interface mm4_out_if;
  import mm4_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  elem_t            prod0;
  elem_t            prod1;
  elem_t            prod2;
  elem_t            prod3;
  logic             last_row;

  modport source (output valid, out_row, prod0, prod1, prod2, prod3, last_row,
                  input ready);
  modport sink   (input valid, out_row, prod0, prod1, prod2, prod3, last_row,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/matrix4_multiply.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// matrix4_multiply
// Signed fixed-point DIM x DIM matrix product (Q16.16 by default), with the
// left and right operands held in internal registers.
// ---------------------------------------------------------------------------
// A request transaction loads one row of the left or right matrix (ignored
// when the row is not below DIM) or starts a multiply; both matrices reset
// to identity. A multiply returns min(DIM,4) product rows, one transaction
// each, the final one flagged by last_row. For each row, one multiplier per
// column lane walks the DIM terms of the dot product, then three pipeline
// stages drain and the row is registered for output. While a multiply runs
// no request is taken; the next request is taken while the last row still
// waits at the output. Elements are floor-shifted by FRAC_BITS and clamped
// to the signed 32-bit range.
module matrix4_multiply #(
  parameter int DIM       = mm4_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  mm4_in_if.sink    item,
  mm4_out_if.source result
);
  import mm4_pkg::*;

  localparam int IDX_W = $clog2(DIM);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] issue_row;
  logic [IDX_W-1:0] issue_k;
  logic [ROW_W-1:0] emit_row;
  elem_t            ld_elems  [IO_COLS];
  elem_t            out_prods [IO_COLS];

  assign ld_elems[0] = item.elem0;
  assign ld_elems[1] = item.elem1;
  assign ld_elems[2] = item.elem2;
  assign ld_elems[3] = item.elem3;

  assign result.prod0 = out_prods[0];
  assign result.prod1 = out_prods[1];
  assign result.prod2 = out_prods[2];
  assign result.prod3 = out_prods[3];

  mm4_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .valid     (item.valid),
    .opcode    (item.opcode),
    .ready     (item.ready),
    .stat      (stat),
    .cmd       (cmd),
    .issue_row (issue_row),
    .issue_k   (issue_k),
    .emit_row  (emit_row)
  );

  mm4_dp #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .issue_row (issue_row),
    .issue_k   (issue_k),
    .emit_row  (emit_row),
    .ld_row    (item.row_index),
    .ld_elems  (ld_elems),
    .stat      (stat),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_row   (result.out_row),
    .out_prods (out_prods),
    .out_last  (result.last_row)
  );

endmodule
`default_nettype wire

@@ hw/rtl/mm4_mac.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mm4_mac
// One column lane: operand register, signed multiply, exact accumulate,
// then floor shift by the fraction bits and 32-bit saturation.
// ---------------------------------------------------------------------------
module mm4_mac #(
  parameter int DIM       = mm4_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          issue,
  input  wire logic          first,
  input  wire logic          last,
  input  wire mm4_pkg::elem_t a,
  input  wire mm4_pkg::elem_t b,
  output mm4_pkg::elem_t     result,
  output logic               done
);
  import mm4_pkg::*;

  localparam int ACC_W = 2 * ELEM_W + $clog2(DIM);
  localparam elem_t SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  elem_t                      a_q;
  elem_t                      b_q;
  logic                       v1, f1, l1;
  logic signed [2*ELEM_W-1:0] prod;
  logic                       v2, f2, l2;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    shifted;
  logic [ACC_W-ELEM_W:0]      hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      f1   <= 1'b0;
      l1   <= 1'b0;
      v2   <= 1'b0;
      f2   <= 1'b0;
      l2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= issue;
      f1   <= first;
      l1   <= last;
      v2   <= v1;
      f2   <= f1;
      l2   <= l1;
      done <= v2 && l2;
    end
  end

  always_ff @(posedge clk) begin
    a_q  <= a;
    b_q  <= b;
    prod <= a_q * b_q;
    if (v2) begin
      if (f2) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  assign shifted = acc >>> FRAC_BITS;
  assign hi      = shifted[ACC_W-1:ELEM_W-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      result = shifted[ELEM_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      result = SAT_MIN;
    end else begin
      result = SAT_MAX;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mm4_dp.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mm4_dp
// Datapath: left/right matrix storage, column MAC lanes and the product row
// output register.
// ---------------------------------------------------------------------------
module mm4_dp #(
  parameter  int DIM       = mm4_pkg::DIM_DEFAULT,
  parameter  int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT,
  localparam int IDX_W     = $clog2(DIM)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mm4_pkg::dp_cmd_t          cmd,
  input  wire logic [IDX_W-1:0]          issue_row,
  input  wire logic [IDX_W-1:0]          issue_k,
  input  wire logic [mm4_pkg::ROW_W-1:0] emit_row,
  input  wire logic [mm4_pkg::ROW_W-1:0] ld_row,
  input  wire mm4_pkg::elem_t            ld_elems [mm4_pkg::IO_COLS],
  output mm4_pkg::dp_stat_t              stat,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [mm4_pkg::ROW_W-1:0]      out_row,
  output mm4_pkg::elem_t                 out_prods [mm4_pkg::IO_COLS],
  output logic                           out_last
);
  import mm4_pkg::*;

  localparam elem_t UNIT = elem_t'(1) << FRAC_BITS;

  elem_t            left_m  [DIM][DIM];
  elem_t            right_m [DIM][DIM];
  elem_t            lane_a;
  elem_t            lane_res [IO_COLS];
  logic [IDX_W-1:0] ld_idx;
  logic             ld_ok;

  assign ld_idx = IDX_W'(ld_row);
  assign ld_ok  = 32'(ld_row) < DIM;
  assign lane_a = left_m[issue_row][issue_k];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          left_m[r][c]  <= (r == c) ? UNIT : '0;
          right_m[r][c] <= (r == c) ? UNIT : '0;
        end
      end
    end else if (ld_ok) begin
      for (int c = 0; c < DIM; c++) begin
        if (cmd.load_left) begin
          left_m[ld_idx][c] <= (c < IO_COLS) ? ld_elems[c] : '0;
        end
        if (cmd.load_right) begin
          right_m[ld_idx][c] <= (c < IO_COLS) ? ld_elems[c] : '0;
        end
      end
    end
  end

  for (genvar j = 0; j < IO_COLS; j++) begin : g_lane
    if (j < DIM) begin : g_mac
      logic lane_done;

      mm4_mac #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
      ) u_mac (
        .clk    (clk),
        .rst    (rst),
        .issue  (cmd.issue),
        .first  (cmd.first),
        .last   (cmd.last),
        .a      (lane_a),
        .b      (right_m[issue_k][j]),
        .result (lane_res[j]),
        .done   (lane_done)
      );

      if (j == 0) begin : g_done
        assign stat.row_done = lane_done;
      end
    end else begin : g_zero
      assign lane_res[j] = '0;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row  <= emit_row;
      out_last <= cmd.emit_last;
      for (int j = 0; j < IO_COLS; j++) begin
        out_prods[j] <= lane_res[j];
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mm4_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mm4_ctrl
// Controller: decodes request transactions, steps the inner-sum index for
// each product row, waits for the lanes and hands rows to the output.
// ---------------------------------------------------------------------------
module mm4_ctrl #(
  parameter  int DIM   = mm4_pkg::DIM_DEFAULT,
  localparam int IDX_W = $clog2(DIM)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         valid,
  input  wire logic [mm4_pkg::OPCODE_W-1:0] opcode,
  output logic                              ready,
  input  wire mm4_pkg::dp_stat_t            stat,
  output mm4_pkg::dp_cmd_t                  cmd,
  output logic [IDX_W-1:0]                  issue_row,
  output logic [IDX_W-1:0]                  issue_k,
  output logic [mm4_pkg::ROW_W-1:0]         emit_row
);
  import mm4_pkg::*;

  localparam int EMIT_ROWS = (DIM < IO_COLS) ? DIM : IO_COLS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] k;
  logic             issue;
  logic             first;
  logic             last;
  logic             emit;
  logic             emit_last;
  logic             accept;

  assign accept = valid && ready;

  assign cmd.load_left  = accept && (opcode == OP_LOAD_LEFT);
  assign cmd.load_right = accept && (opcode == OP_LOAD_RIGHT);
  assign cmd.issue      = issue;
  assign cmd.first      = first;
  assign cmd.last       = last;
  assign cmd.emit       = emit;
  assign cmd.emit_last  = emit_last;
  assign issue_row      = row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ready     <= 1'b1;
      row       <= '0;
      k         <= '0;
      issue_k   <= '0;
      issue     <= 1'b0;
      first     <= 1'b0;
      last      <= 1'b0;
      emit      <= 1'b0;
      emit_last <= 1'b0;
      emit_row  <= '0;
    end else begin
      issue <= 1'b0;
      first <= 1'b0;
      last  <= 1'b0;
      emit  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && (opcode == OP_MULTIPLY)) begin
            ready <= 1'b0;
            row   <= '0;
            k     <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          issue   <= 1'b1;
          issue_k <= k;
          first   <= (k == '0);
          last    <= (k == IDX_W'(DIM - 1));
          if (k == IDX_W'(DIM - 1)) begin
            k     <= '0;
            state <= S_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DRAIN: begin
          if (stat.row_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (stat.out_free) begin
            emit      <= 1'b1;
            emit_row  <= ROW_W'(row);
            emit_last <= (row == IDX_W'(EMIT_ROWS - 1));
            if (row == IDX_W'(EMIT_ROWS - 1)) begin
              ready <= 1'b1;
              state <= S_IDLE;
            end else begin
              row   <= row + 1'b1;
              state <= S_ISSUE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
